// File: hw/rtl/tlg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlg_pkg: shared types and codes for the two-leg gait phase FSM
// Payload structs, register indexes, phase/gain codes and per-leg functions.
// ----------------------------------------------------------------------------
package tlg_pkg;

  localparam int unsigned AngleW = 16;

  // Configuration register indexes
  localparam logic [1:0] CFG_PRESWING_STEP_TH = 2'd0;
  localparam logic [1:0] CFG_RELAX_STEP_TH    = 2'd1;
  localparam logic [1:0] CFG_RELAX_ANGLE_TH   = 2'd2;
  localparam logic [1:0] CFG_LOCK_POSITION    = 2'd3;

  // Walking intention codes
  localparam logic [1:0] INTENT_NONE  = 2'd0;
  localparam logic [1:0] INTENT_LEFT  = 2'd1;
  localparam logic [1:0] INTENT_RIGHT = 2'd2;

  // Phase codes as reported on the result channel
  localparam logic [2:0] PH_LOCK     = 3'd0;
  localparam logic [2:0] PH_SAFE     = 3'd1;
  localparam logic [2:0] PH_PRESWING = 3'd2;
  localparam logic [2:0] PH_SWING    = 3'd3;
  localparam logic [2:0] PH_RELAX    = 3'd4;

  // Gain-set selectors
  localparam logic [1:0] GAIN_LOCK  = 2'd0;
  localparam logic [1:0] GAIN_SAFE  = 2'd1;
  localparam logic [1:0] GAIN_SWING = 2'd2;
  localparam logic [1:0] GAIN_RELAX = 2'd3;

  // Internal per-leg phase, one-hot
  typedef enum logic [4:0] {
    LEG_LOCK     = 5'b00001,
    LEG_SAFE     = 5'b00010,
    LEG_PRESWING = 5'b00100,
    LEG_SWING    = 5'b01000,
    LEG_RELAX    = 5'b10000
  } phase_t;

  typedef struct packed {
    logic                     error_flag;
    logic [1:0]               intention;
    logic signed [AngleW-1:0] step_height;
    logic signed [AngleW-1:0] hip_left;
    logic signed [AngleW-1:0] hip_right;
    logic signed [AngleW-1:0] knee_left;
    logic signed [AngleW-1:0] knee_right;
    logic signed [AngleW-1:0] knee_target_left;
    logic signed [AngleW-1:0] knee_target_right;
  } in_t;

  typedef struct packed {
    logic [2:0]               phase_left;
    logic [2:0]               phase_right;
    logic [1:0]               gains_left;
    logic [1:0]               gains_right;
    logic signed [AngleW-1:0] position_left;
    logic signed [AngleW-1:0] position_right;
    logic                     comp_left;
    logic                     comp_right;
  } out_t;

  typedef struct packed {
    logic signed [AngleW-1:0] preswing_step_th;
    logic signed [AngleW-1:0] relax_step_th;
    logic signed [AngleW-1:0] relax_angle_th;
    logic signed [AngleW-1:0] lock_position;
  } cfg_t;

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    case (ph)
      LEG_LOCK:     code = PH_LOCK;
      LEG_PRESWING: code = PH_PRESWING;
      LEG_SWING:    code = PH_SWING;
      LEG_RELAX:    code = PH_RELAX;
      default:      code = PH_SAFE;
    endcase
    return code;
  endfunction

  function automatic logic [1:0] phase_gains(input phase_t ph);
    logic [1:0] g;
    case (ph)
      LEG_LOCK, LEG_PRESWING: g = GAIN_LOCK;
      LEG_SWING:              g = GAIN_SWING;
      LEG_RELAX:              g = GAIN_RELAX;
      default:                g = GAIN_SAFE;
    endcase
    return g;
  endfunction

  // Next phase of one leg from the phases held before the tick
  function automatic phase_t next_phase(
    input phase_t                   prev,
    input phase_t                   other_prev,
    input logic [1:0]               leg_intent,
    input logic [1:0]               intent,
    input logic signed [AngleW-1:0] step,
    input logic signed [AngleW-1:0] hip,
    input logic signed [AngleW-1:0] knee,
    input cfg_t                     cfg
  );
    phase_t nxt;
    case (prev)
      LEG_LOCK: begin
        nxt = (intent == leg_intent && other_prev == LEG_LOCK) ? LEG_PRESWING : LEG_LOCK;
      end
      LEG_PRESWING: begin
        if (intent != leg_intent) begin
          nxt = LEG_LOCK;
        end else if (step >= cfg.preswing_step_th) begin
          nxt = LEG_SWING;
        end else begin
          nxt = LEG_PRESWING;
        end
      end
      LEG_SWING: begin
        if (intent == INTENT_NONE ||
            (step < cfg.relax_step_th && hip < cfg.relax_angle_th)) begin
          nxt = LEG_RELAX;
        end else begin
          nxt = LEG_SWING;
        end
      end
      LEG_RELAX: begin
        nxt = (knee < cfg.relax_angle_th) ? LEG_LOCK : LEG_RELAX;
      end
      default: begin
        nxt = LEG_LOCK;
      end
    endcase
    return nxt;
  endfunction

endpackage

// File: hw/rtl/two_leg_gait_phase_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_leg_gait_phase_fsm: gait phase sequencer for a two-leg exoskeleton
// Tracks lock/safe/pre-swing/swing/relax per leg and reports gains,
// position setpoints and torque-compensation enables once per tick.
// ----------------------------------------------------------------------------
// Each input transaction is one control tick. The block accepts one
// transaction per clock cycle while the result side is not stalled, and
// returns exactly one result transaction for it, after it has passed
// through the input register and then the result register. Both legs step
// from the phases held before the tick; an error flag sends both to safe.
// Both legs come out of reset in safe and move to lock on the first clean
// tick. Angles and thresholds are signed 16-bit values in 0.01 degree;
// every compare is strict except the pre-swing exit (step >= threshold).
// Write configuration only while no transaction is in flight.
// ----------------------------------------------------------------------------
module two_leg_gait_phase_fsm (
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  tlg_pkg::in_t     in_data,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output tlg_pkg::out_t    out_data,
  // configuration write port
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [tlg_pkg::AngleW-1:0] cfg_wdata
);

  // Configuration registers
  tlg_pkg::cfg_t   cfg_r, cfg_nxt;

  // Input register stage
  logic            s1_valid_r, s1_valid_nxt;
  tlg_pkg::in_t    s1_data_r;

  // Leg phase state
  tlg_pkg::phase_t leg_l_r, leg_l_nxt;
  tlg_pkg::phase_t leg_r_r, leg_r_nxt;

  // Result register
  logic            out_valid_r, out_valid_nxt;
  tlg_pkg::out_t   out_data_r, out_data_nxt;

  logic            in_take;
  logic            adv;

  // Result register frees up when empty or being drained this cycle
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        tlg_pkg::CFG_PRESWING_STEP_TH: cfg_nxt.preswing_step_th = cfg_wdata;
        tlg_pkg::CFG_RELAX_STEP_TH:    cfg_nxt.relax_step_th    = cfg_wdata;
        tlg_pkg::CFG_RELAX_ANGLE_TH:   cfg_nxt.relax_angle_th   = cfg_wdata;
        tlg_pkg::CFG_LOCK_POSITION:    cfg_nxt.lock_position    = cfg_wdata;
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  // Hold the input register while the result side is blocked; refill on take
  always_comb begin
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  // Phase update: both legs from the previous phases, error forces safe
  always_comb begin
    leg_l_nxt = leg_l_r;
    leg_r_nxt = leg_r_r;
    if (s1_valid_r && adv) begin
      if (s1_data_r.error_flag) begin
        leg_l_nxt = tlg_pkg::LEG_SAFE;
        leg_r_nxt = tlg_pkg::LEG_SAFE;
      end else begin
        leg_l_nxt = tlg_pkg::next_phase(leg_l_r, leg_r_r, tlg_pkg::INTENT_LEFT,
                                        s1_data_r.intention, s1_data_r.step_height,
                                        s1_data_r.hip_left, s1_data_r.knee_left, cfg_r);
        leg_r_nxt = tlg_pkg::next_phase(leg_r_r, leg_l_r, tlg_pkg::INTENT_RIGHT,
                                        s1_data_r.intention, s1_data_r.step_height,
                                        s1_data_r.hip_right, s1_data_r.knee_right, cfg_r);
      end
    end
  end

  // Result from the new phases; swing drives the knee target, else lock position
  always_comb begin
    out_data_nxt.phase_left     = tlg_pkg::phase_code(leg_l_nxt);
    out_data_nxt.phase_right    = tlg_pkg::phase_code(leg_r_nxt);
    out_data_nxt.gains_left     = tlg_pkg::phase_gains(leg_l_nxt);
    out_data_nxt.gains_right    = tlg_pkg::phase_gains(leg_r_nxt);
    out_data_nxt.position_left  = (leg_l_nxt == tlg_pkg::LEG_SWING) ?
                                  s1_data_r.knee_target_left : cfg_r.lock_position;
    out_data_nxt.position_right = (leg_r_nxt == tlg_pkg::LEG_SWING) ?
                                  s1_data_r.knee_target_right : cfg_r.lock_position;
    out_data_nxt.comp_left      = (leg_l_nxt == tlg_pkg::LEG_SWING) ||
                                  (leg_l_nxt == tlg_pkg::LEG_RELAX);
    out_data_nxt.comp_right     = (leg_r_nxt == tlg_pkg::LEG_SWING) ||
                                  (leg_r_nxt == tlg_pkg::LEG_RELAX);
  end

  assign out_valid_nxt = adv ? s1_valid_r : out_valid_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      leg_l_r     <= tlg_pkg::LEG_SAFE;
      leg_r_r     <= tlg_pkg::LEG_SAFE;
    end else begin
      cfg_r       <= cfg_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      leg_l_r     <= leg_l_nxt;
      leg_r_r     <= leg_r_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (s1_valid_r && adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  // An error tick leaves both legs in safe
  a_error_safe: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && adv && s1_data_r.error_flag) |=>
      (leg_l_r == tlg_pkg::LEG_SAFE && leg_r_r == tlg_pkg::LEG_SAFE &&
       out_data_r.phase_left == tlg_pkg::PH_SAFE &&
       out_data_r.phase_right == tlg_pkg::PH_SAFE))
    else $error("error tick did not force both legs to safe");

  // Only one leg may be stepping (pre-swing, swing or relax) at a time
  a_one_leg_moving: assert property (@(posedge clk) disable iff (!rst_n)
    !((leg_l_r == tlg_pkg::LEG_PRESWING || leg_l_r == tlg_pkg::LEG_SWING ||
       leg_l_r == tlg_pkg::LEG_RELAX) &&
      (leg_r_r == tlg_pkg::LEG_PRESWING || leg_r_r == tlg_pkg::LEG_SWING ||
       leg_r_r == tlg_pkg::LEG_RELAX)))
    else $error("both legs out of lock/safe at once");

  // Phases move only when a tick passes into the result register
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_valid_r && adv) |=> ($stable(leg_l_r) && $stable(leg_r_r)))
    else $error("leg phase changed without a tick");

  // A result in flight reports the phases now held
  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && adv) |=>
      (out_valid_r && out_data_r.phase_left == tlg_pkg::phase_code(leg_l_r) &&
       out_data_r.phase_right == tlg_pkg::phase_code(leg_r_r)))
    else $error("result phase differs from held phase");

endmodule

// File: tb/two_leg_gait_phase_fsm_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_leg_gait_phase_fsm_tb: self-checking bench for the gait phase sequencer
// Drives control ticks through the input channel, tracks both legs' phases in
// a local predictor and compares every result transaction field by field.
// ----------------------------------------------------------------------------
module two_leg_gait_phase_fsm_tb;
  import tlg_pkg::*;

  // Intention code that names no leg
  localparam logic [1:0] INTENT_INVALID = 2'd3;
  // Cycles without any accepted transaction before the run is declared hung
  localparam int WatchdogLimit = 1000;
  localparam int SegmentTicks  = 120;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_t              out_data;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [AngleW-1:0] cfg_wdata = '0;

  // Predictor state: register copy and the phase code of each leg
  cfg_t       model_cfg = '0;
  logic [2:0] model_phase_l = PH_SAFE;
  logic [2:0] model_phase_r = PH_SAFE;
  out_t       pending_results[$];

  int         mismatches = 0;
  int         quiet_cycles = 0;
  int         stall_left = 0;
  logic       idle_on = 1'b1;
  logic [1:0] walk_intent = INTENT_NONE;

  two_leg_gait_phase_fsm u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Treat unreachable phase codes as safe
  function automatic logic [2:0] legal_phase(input logic [2:0] ph);
    return (ph > PH_RELAX) ? PH_SAFE : ph;
  endfunction

  // Next phase of one leg, from both phases held before the tick
  function automatic logic [2:0] leg_next(
    input logic [2:0]        prev,
    input logic [2:0]        other,
    input logic [1:0]        leg_id,
    input logic [1:0]        intent,
    input logic signed [15:0] step,
    input logic signed [15:0] hip,
    input logic signed [15:0] knee
  );
    logic [2:0] nxt;
    nxt = legal_phase(prev);
    case (nxt)
      PH_LOCK: begin
        if (intent == leg_id && legal_phase(other) == PH_LOCK) nxt = PH_PRESWING;
      end
      PH_SAFE: begin
        nxt = PH_LOCK;
      end
      PH_PRESWING: begin
        if (intent != leg_id) nxt = PH_LOCK;
        else if (step >= model_cfg.preswing_step_th) nxt = PH_SWING;
      end
      PH_SWING: begin
        if (intent == INTENT_NONE ||
            (step < model_cfg.relax_step_th && hip < model_cfg.relax_angle_th)) begin
          nxt = PH_RELAX;
        end
      end
      PH_RELAX: begin
        if (knee < model_cfg.relax_angle_th) nxt = PH_LOCK;
      end
      default: begin
        nxt = PH_LOCK;
      end
    endcase
    return nxt;
  endfunction

  function automatic logic [1:0] leg_gains(input logic [2:0] ph);
    logic [1:0] g;
    case (legal_phase(ph))
      PH_LOCK, PH_PRESWING: g = GAIN_LOCK;
      PH_SWING:             g = GAIN_SWING;
      PH_RELAX:             g = GAIN_RELAX;
      default:              g = GAIN_SAFE;
    endcase
    return g;
  endfunction

  // Advance both legs by one tick and build the expected result
  task automatic step_gait_model(input in_t t, output out_t r);
    logic [2:0] nl;
    logic [2:0] nr;
    if (t.error_flag) begin
      nl = PH_SAFE;
      nr = PH_SAFE;
    end else begin
      nl = leg_next(model_phase_l, model_phase_r, INTENT_LEFT, t.intention,
                    t.step_height, t.hip_left, t.knee_left);
      nr = leg_next(model_phase_r, model_phase_l, INTENT_RIGHT, t.intention,
                    t.step_height, t.hip_right, t.knee_right);
    end
    model_phase_l    = nl;
    model_phase_r    = nr;
    r.phase_left     = nl;
    r.phase_right    = nr;
    r.gains_left     = leg_gains(nl);
    r.gains_right    = leg_gains(nr);
    r.position_left  = (nl == PH_SWING) ? t.knee_target_left : model_cfg.lock_position;
    r.position_right = (nr == PH_SWING) ? t.knee_target_right : model_cfg.lock_position;
    r.comp_left      = (nl == PH_SWING || nl == PH_RELAX);
    r.comp_right     = (nr == PH_SWING || nr == PH_RELAX);
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  // Compare each accepted result transaction with the oldest expectation
  always @(posedge clk) begin : result_checker
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result transaction", 16'(out_data.phase_left), '0);
      end else begin
        want = pending_results.pop_front();
        check_field("phase_left", 16'(out_data.phase_left), 16'(want.phase_left));
        check_field("phase_right", 16'(out_data.phase_right), 16'(want.phase_right));
        check_field("gains_left", 16'(out_data.gains_left), 16'(want.gains_left));
        check_field("gains_right", 16'(out_data.gains_right), 16'(want.gains_right));
        check_field("position_left", out_data.position_left, want.position_left);
        check_field("position_right", out_data.position_right, want.position_right);
        check_field("comp_left", 16'(out_data.comp_left), 16'(want.comp_left));
        check_field("comp_right", 16'(out_data.comp_right), 16'(want.comp_right));
      end
    end
  end

  // Hold the result side off in random bursts while idling is enabled
  always @(posedge clk) begin : result_backpressure
    if (!idle_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // End the run if no transaction of any kind moves for too long
  always @(posedge clk) begin : watchdog
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------

  // Offer one tick, optionally after a gap, and hold it until accepted
  task automatic send_tick(input in_t t);
    out_t r;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    step_gait_model(t, r);
    pending_results.push_back(r);
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One configuration write; the caller lowers the write enable after the last one
  task automatic cfg_cycle(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic apply_config(input cfg_t c);
    cfg_cycle(CFG_PRESWING_STEP_TH, c.preswing_step_th);
    cfg_cycle(CFG_RELAX_STEP_TH, c.relax_step_th);
    cfg_cycle(CFG_RELAX_ANGLE_TH, c.relax_angle_th);
    cfg_cycle(CFG_LOCK_POSITION, c.lock_position);
    cfg_we    <= 1'b0;
    model_cfg = c;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic logic signed [15:0] random_threshold();
    logic signed [15:0] v;
    case ($urandom_range(0, 5))
      0:       v = -16'sd32768;
      1:       v = 16'sd32767;
      2:       v = -16'sd18000;
      3:       v = 16'sd18000;
      4:       v = 16'(int'($urandom_range(0, 400)) - 200);
      default: v = 16'(int'($urandom_range(0, 36000)) - 18000);
    endcase
    return v;
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.preswing_step_th = random_threshold();
    c.relax_step_th    = random_threshold();
    c.relax_angle_th   = random_threshold();
    c.lock_position    = random_threshold();
    return c;
  endfunction

  // A value within a few counts of a threshold; wraps at the 16-bit ends
  function automatic logic signed [15:0] near(input logic signed [15:0] th);
    logic signed [15:0] v;
    v = 16'(int'(th) + int'($urandom_range(0, 8)) - 4);
    return v;
  endfunction

  function automatic logic signed [15:0] random_angle();
    logic signed [15:0] v;
    if ($urandom_range(0, 3) == 0) v = 16'($urandom());
    else v = 16'(int'($urandom_range(0, 36000)) - 18000);
    return v;
  endfunction

  function automatic logic signed [15:0] joint_angle();
    return ($urandom_range(0, 1) == 0) ? near(model_cfg.relax_angle_th) : random_angle();
  endfunction

  // Random tick around the current thresholds with a sticky intention, so
  // most sequences walk a leg through pre-swing, swing and relax
  task automatic random_tick(output in_t t);
    if ($urandom_range(0, 5) == 0) walk_intent = 2'($urandom_range(0, 3));
    t.error_flag = ($urandom_range(0, 39) == 0);
    if ($urandom_range(0, 9) == 0) t.intention = 2'($urandom_range(0, 3));
    else t.intention = walk_intent;
    case ($urandom_range(0, 2))
      0:       t.step_height = near(model_cfg.preswing_step_th);
      1:       t.step_height = near(model_cfg.relax_step_th);
      default: t.step_height = 16'($urandom());
    endcase
    t.hip_left          = joint_angle();
    t.hip_right         = joint_angle();
    t.knee_left         = joint_angle();
    t.knee_right        = joint_angle();
    t.knee_target_left  = random_angle();
    t.knee_target_right = random_angle();
  endtask

  task automatic send_random_ticks(input int count);
    in_t t;
    repeat (count) begin
      random_tick(t);
      send_tick(t);
    end
  endtask

  task automatic send_fields(
    input logic              err,
    input logic [1:0]        intent,
    input logic signed [15:0] step,
    input logic signed [15:0] hl,
    input logic signed [15:0] hr,
    input logic signed [15:0] kl,
    input logic signed [15:0] kr,
    input logic signed [15:0] tl,
    input logic signed [15:0] tr
  );
    in_t t;
    t.error_flag        = err;
    t.intention         = intent;
    t.step_height       = step;
    t.hip_left          = hl;
    t.hip_right         = hr;
    t.knee_left         = kl;
    t.knee_right        = kr;
    t.knee_target_left  = tl;
    t.knee_target_right = tr;
    send_tick(t);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Walk each leg through every phase, hitting the pre-swing, hip and knee threshold ties
  task automatic test_directed_walk();
    cfg_t c;
    c.preswing_step_th = 16'sd100;
    c.relax_step_th    = 16'sd50;
    c.relax_angle_th   = 16'sd0;
    c.lock_position    = -16'sd18000;
    apply_config(c);
    // safe to lock, then the invalid intention keeps both legs in lock
    send_fields(0, INTENT_NONE, 0, 1, 1, 1, 1, 18000, -18000);
    send_fields(0, INTENT_INVALID, 32767, 1, 1, 1, 1, 18000, -18000);
    // left: pre-swing, hold below threshold, swing on the tie
    send_fields(0, INTENT_LEFT, 99, 1, 1, 1, 1, 18000, -18000);
    send_fields(0, INTENT_LEFT, 99, 1, 1, 1, 1, 18000, -18000);
    send_fields(0, INTENT_LEFT, 100, 1, 1, 1, 1, 18000, -18000);
    // stay in swing: step too high, then hip on the tie with invalid intention
    send_fields(0, INTENT_RIGHT, 32767, -18000, 1, 1, 1, 18000, -18000);
    send_fields(0, INTENT_INVALID, -32768, 0, 1, 1, 1, -18000, -18000);
    // swing to relax on step and hip, relax holds on the knee tie, then lock
    send_fields(0, INTENT_LEFT, 49, -1, 1, 1, 1, 18000, -18000);
    send_fields(0, INTENT_LEFT, 0, 1, 1, 0, 1, 18000, -18000);
    send_fields(0, INTENT_LEFT, 0, 1, 1, -18000, 1, 18000, -18000);
    // right: pre-swing falls back to lock on the invalid intention
    send_fields(0, INTENT_RIGHT, 32767, 1, 1, 1, 1, 18000, -18000);
    send_fields(0, INTENT_INVALID, 0, 1, 1, 1, 1, 18000, -18000);
    send_fields(0, INTENT_RIGHT, 100, 1, 1, 1, 1, 18000, -18000);
    send_fields(0, INTENT_RIGHT, 100, 1, 1, 1, 1, 18000, -18000);
    // no intention sends swing to relax
    send_fields(0, INTENT_NONE, 100, 1, 1, 1, 1, 18000, 18000);
    // error forces safe regardless of the extreme fields
    send_fields(1, INTENT_INVALID, -32768, -32768, 32767, -32768, 32767, -32768, 32767);
    send_fields(1, INTENT_NONE, 32767, 32767, -32768, 32767, -32768, 32767, -32768);
    send_fields(0, INTENT_NONE, 0, 0, 0, 0, 0, 0, 0);
    wait_drained();
  endtask

  // Registers at the ends of their range, then a mix of end and mid-range values
  task automatic test_register_extremes();
    cfg_t c;
    c = {4{-16'sd32768}};
    apply_config(c);
    send_random_ticks(40);
    wait_drained();
    c = {4{16'sd32767}};
    apply_config(c);
    send_random_ticks(40);
    wait_drained();
    c.preswing_step_th = 16'sd32767;
    c.relax_step_th    = -16'sd32768;
    c.relax_angle_th   = -16'sd18000;
    c.lock_position    = 16'sd18000;
    apply_config(c);
    send_random_ticks(40);
    wait_drained();
  endtask

  // Random segments, each with its own settings; every third one runs with
  // no idling. Each segment ends with the sender paused until drained.
  task automatic test_random_walks();
    for (int seg = 0; seg < 9; seg++) begin
      idle_on <= (seg % 3 != 2);
      apply_config(random_cfg());
      send_random_ticks(SegmentTicks);
      wait_drained();
    end
  endtask

  // Back-to-back ticks with no idling on either side
  task automatic test_steady_stream();
    idle_on <= 1'b0;
    apply_config(random_cfg());
    send_random_ticks(200);
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_walk();
    test_register_extremes();
    test_random_walks();
    test_steady_stream();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/tlg_pkg.sv
hw/rtl/two_leg_gait_phase_fsm.sv
tb/two_leg_gait_phase_fsm_tb.sv
